### hw/rtl/rgbab_pkg.sv
// rgbab_pkg: types, constants and helper functions for the rgb565 alpha blender
// depends on nothing; used by rgbab_front, rgbab_lane, the blender and its checker
`timescale 1ns / 1ps
`default_nettype none
package rgbab_pkg;

	localparam logic [7:0]  OPAQUE_MIN   = 8'd250;
	localparam logic [7:0]  ALPHA_FULL   = 8'd255;
	localparam logic [15:0] ROUND_BIAS   = 16'd127;
	localparam logic [7:0]  RED_KEEP     = 8'hF8;
	localparam logic [7:0]  GREEN_KEEP   = 8'hFC;

	// per-beat mode flags that ride along the pipe
	typedef struct packed {
		logic opaque;
		logic transp;
	} mode_t;

	// floor(c*255/31) = 8c + floor(7c/31); the second term steps at fixed thresholds
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [2:0] k;
		k = 3'd0;
		if (c >= 5'd5)  k = 3'd1;
		if (c >= 5'd9)  k = 3'd2;
		if (c >= 5'd14) k = 3'd3;
		if (c >= 5'd18) k = 3'd4;
		if (c >= 5'd23) k = 3'd5;
		if (c >= 5'd27) k = 3'd6;
		if (c >= 5'd31) k = 3'd7;
		return {c, 3'b000} + {5'd0, k};
	endfunction

	// floor(c*255/63) = 4c + floor(c/21)
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [1:0] k;
		k = 2'd0;
		if (c >= 6'd21) k = 2'd1;
		if (c >= 6'd42) k = 2'd2;
		if (c >= 6'd63) k = 2'd3;
		return {c, 2'b00} + {6'd0, k};
	endfunction

	// truncate 8-8-8 to 5-6-5
	function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [7:0] rk;
		logic [7:0] gk;
		rk = r & RED_KEEP;
		gk = g & GREEN_KEEP;
		return {rk[7:3], gk[7:2], b[7:3]};
	endfunction

	// floor(x/255), exact for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/rgbab_front.sv
// rgbab_front: first pipe stage, decodes alpha mode and expands the rgb565 destination
// depends on rgbab_pkg
`timescale 1ns / 1ps
`default_nettype none
module rgbab_front import rgbab_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [7:0]            src_alpha,
	input  wire logic [7:0]            src_red,
	input  wire logic [7:0]            src_green,
	input  wire logic [7:0]            src_blue,
	input  wire logic [15:0]           dest_pixel,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	output logic                       valid_s1,
	output mode_t                      mode_s1,
	output logic [7:0]                 alpha_s1,
	output logic [7:0]                 inv_alpha_s1,
	output logic [7:0]                 sr_s1,
	output logic [7:0]                 sg_s1,
	output logic [7:0]                 sb_s1,
	output logic [7:0]                 dr_s1,
	output logic [7:0]                 dg_s1,
	output logic [7:0]                 db_s1,
	output logic [15:0]                dest_s1,
	output logic [15:0]                opq_word_s1,
	output logic [COORD_BITS-1:0]      x_s1,
	output logic [COORD_BITS-1:0]      y_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1.opaque <= (src_alpha >= OPAQUE_MIN);
		mode_s1.transp <= (src_alpha == 8'd0);
		alpha_s1       <= src_alpha;
		inv_alpha_s1   <= ALPHA_FULL - src_alpha;
		sr_s1          <= src_red;
		sg_s1          <= src_green;
		sb_s1          <= src_blue;
		dr_s1          <= expand5(dest_pixel[15:11]);
		dg_s1          <= expand6(dest_pixel[10:5]);
		db_s1          <= expand5(dest_pixel[4:0]);
		dest_s1        <= dest_pixel;
		opq_word_s1    <= pack565(src_red, src_green, src_blue);
		x_s1           <= pixel_x;
		y_s1           <= pixel_y;
	end

endmodule
`default_nettype wire

### hw/rtl/rgbab_lane.sv
// rgbab_lane: one color channel, multiply stage then sum stage, rounded /255 out
// depends on rgbab_pkg
`timescale 1ns / 1ps
`default_nettype none
module rgbab_lane import rgbab_pkg::*; (
	input  wire logic       clk,
	input  wire logic [7:0] src_s1,
	input  wire logic [7:0] dst_s1,
	input  wire logic [7:0] alpha_s1,
	input  wire logic [7:0] inv_alpha_s1,
	output logic [7:0]      mixed
);

	logic [15:0] src_prod_s2;
	logic [15:0] dst_prod_s2;
	logic [15:0] sum_s3;

	// two 8x8 products
	always_ff @(posedge clk) begin
		src_prod_s2 <= src_s1 * alpha_s1;
		dst_prod_s2 <= dst_s1 * inv_alpha_s1;
	end

	// total stays at or below 255*255+127, fits 16 bits
	always_ff @(posedge clk) begin
		sum_s3 <= src_prod_s2 + dst_prod_s2 + ROUND_BIAS;
	end

	assign mixed = div255(sum_s3);

endmodule
`default_nettype wire

### hw/rtl/rgb565_alpha_blend_pixel.sv
// rgb565_alpha_blend_pixel: source-over blend of argb8888 onto an rgb565 pixel
// depends on rgbab_pkg, rgbab_front, rgbab_lane
// throughput: one beat per cycle; busy is held low, the pipe never stalls
// the stage count is set by front decode, the 8x8 multiplies, the sum and the /255 + pack
// reset: arst_n clears all valid bits at once; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module rgb565_alpha_blend_pixel import rgbab_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command side
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [7:0]            src_alpha,
	input  wire logic [7:0]            src_red,
	input  wire logic [7:0]            src_green,
	input  wire logic [7:0]            src_blue,
	input  wire logic [15:0]           dest_pixel,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	// result side, one-cycle strobe
	output logic                       done,
	output logic [15:0]                new_pixel,
	output logic                       write_enable,
	output logic [COORD_BITS-1:0]      write_x,
	output logic [COORD_BITS-1:0]      write_y
);

	// stage 1 outputs
	logic                  valid_s1;
	mode_t                 mode_s1;
	logic [7:0]            alpha_s1;
	logic [7:0]            inv_alpha_s1;
	logic [7:0]            sr_s1;
	logic [7:0]            sg_s1;
	logic [7:0]            sb_s1;
	logic [7:0]            dr_s1;
	logic [7:0]            dg_s1;
	logic [7:0]            db_s1;
	logic [15:0]           dest_s1;
	logic [15:0]           opq_word_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;

	// sideband that rides alongside the lanes
	logic                  valid_s2;
	logic                  valid_s3;
	logic                  valid_s4;
	mode_t                 mode_s2;
	mode_t                 mode_s3;
	logic [15:0]           dest_s2;
	logic [15:0]           dest_s3;
	logic [15:0]           opq_word_s2;
	logic [15:0]           opq_word_s3;
	logic [COORD_BITS-1:0] x_s2;
	logic [COORD_BITS-1:0] x_s3;
	logic [COORD_BITS-1:0] x_s4;
	logic [COORD_BITS-1:0] y_s2;
	logic [COORD_BITS-1:0] y_s3;
	logic [COORD_BITS-1:0] y_s4;
	logic [15:0]           word_s4;
	logic                  we_s4;

	// blended channels, valid alongside stage 3
	logic [7:0] mix_r;
	logic [7:0] mix_g;
	logic [7:0] mix_b;

	// every stage advances each cycle, so a new beat is always welcome
	assign busy = 1'b0;

	rgbab_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start),
		.src_alpha    (src_alpha),
		.src_red      (src_red),
		.src_green    (src_green),
		.src_blue     (src_blue),
		.dest_pixel   (dest_pixel),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.valid_s1     (valid_s1),
		.mode_s1      (mode_s1),
		.alpha_s1     (alpha_s1),
		.inv_alpha_s1 (inv_alpha_s1),
		.sr_s1        (sr_s1),
		.sg_s1        (sg_s1),
		.sb_s1        (sb_s1),
		.dr_s1        (dr_s1),
		.dg_s1        (dg_s1),
		.db_s1        (db_s1),
		.dest_s1      (dest_s1),
		.opq_word_s1  (opq_word_s1),
		.x_s1         (x_s1),
		.y_s1         (y_s1)
	);

	// one lane per color channel, two register stages each
	rgbab_lane u_lane_r (
		.clk          (clk),
		.src_s1       (sr_s1),
		.dst_s1       (dr_s1),
		.alpha_s1     (alpha_s1),
		.inv_alpha_s1 (inv_alpha_s1),
		.mixed        (mix_r)
	);

	rgbab_lane u_lane_g (
		.clk          (clk),
		.src_s1       (sg_s1),
		.dst_s1       (dg_s1),
		.alpha_s1     (alpha_s1),
		.inv_alpha_s1 (inv_alpha_s1),
		.mixed        (mix_g)
	);

	rgbab_lane u_lane_b (
		.clk          (clk),
		.src_s1       (sb_s1),
		.dst_s1       (db_s1),
		.alpha_s1     (alpha_s1),
		.inv_alpha_s1 (inv_alpha_s1),
		.mixed        (mix_b)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// sideband payload, no reset needed
	always_ff @(posedge clk) begin
		mode_s2     <= mode_s1;
		mode_s3     <= mode_s2;
		dest_s2     <= dest_s1;
		dest_s3     <= dest_s2;
		opq_word_s2 <= opq_word_s1;
		opq_word_s3 <= opq_word_s2;
		x_s2        <= x_s1;
		x_s3        <= x_s2;
		x_s4        <= x_s3;
		y_s2        <= y_s1;
		y_s3        <= y_s2;
		y_s4        <= y_s3;
	end

	// output stage: pick opaque copy, untouched destination, or the blend
	always_ff @(posedge clk) begin
		if (mode_s3.opaque) begin
			word_s4 <= opq_word_s3;
			we_s4   <= 1'b1;
		end else if (mode_s3.transp) begin
			word_s4 <= dest_s3;
			we_s4   <= 1'b0;
		end else begin
			word_s4 <= pack565(mix_r, mix_g, mix_b);
			we_s4   <= 1'b1;
		end
	end

	assign done         = valid_s4;
	assign new_pixel    = word_s4;
	assign write_enable = we_s4;
	assign write_x      = x_s4;
	assign write_y      = y_s4;

endmodule
`default_nettype wire

### bench/rgb565_alpha_blend_pixel_chk.sv
// rgb565_alpha_blend_pixel_chk: watches both channels of the blender, predicts each result beat
// depends on rgbab_pkg for the opaque threshold and the channel keep masks
`timescale 1ns / 1ps
module rgb565_alpha_blend_pixel_chk import rgbab_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [7:0]            src_alpha,
	input  logic [7:0]            src_red,
	input  logic [7:0]            src_green,
	input  logic [7:0]            src_blue,
	input  logic [15:0]           dest_pixel,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic                  done,
	input  logic [15:0]           new_pixel,
	input  logic                  write_enable,
	input  logic [COORD_BITS-1:0] write_x,
	input  logic [COORD_BITS-1:0] write_y,
	output int                    error_count,
	output int                    writes_outstanding
);

	typedef struct {
		logic [15:0]           word;
		logic                  we;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} frame_write_t;

	frame_write_t pending_writes[$];

	function automatic logic [15:0] pack_565(input int unsigned r, input int unsigned g,
		input int unsigned b);
		logic [7:0] rk;
		logic [7:0] gk;
		logic [7:0] bk;
		rk = 8'(r) & RED_KEEP;
		gk = 8'(g) & GREEN_KEEP;
		bk = 8'(b);
		return {rk[7:3], gk[7:2], bk[7:3]};
	endfunction

	function automatic int unsigned mix(input int unsigned s, input int unsigned d,
		input int unsigned a);
		return (s * a + d * (255 - a) + 127) / 255;
	endfunction

	function automatic frame_write_t blend_pixel(input logic [7:0] a, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [15:0] dp,
		input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		frame_write_t fw;
		int unsigned dr;
		int unsigned dg;
		int unsigned db;
		fw.x = x;
		fw.y = y;
		fw.we = 1'b1;
		if (a >= OPAQUE_MIN) begin
			fw.word = pack_565(r, g, b);
		end else if (a == 8'd0) begin
			fw.word = dp;
			fw.we = 1'b0;
		end else begin
			// widen destination to 8 bits per channel, floored
			dr = int'(dp[15:11]) * 255 / 31;
			dg = int'(dp[10:5]) * 255 / 63;
			db = int'(dp[4:0]) * 255 / 31;
			fw.word = pack_565(mix(r, dr, a), mix(g, dg, a), mix(b, db, a));
		end
		return fw;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_write_t fw;
		if (!arst_n) begin
			pending_writes.delete();
			writes_outstanding <= 0;
			error_count <= 0;
		end else begin
			if (done) begin
				if (pending_writes.size() == 0) begin
					$error("result beat with nothing expected: new_pixel %h", new_pixel);
					error_count <= error_count + 1;
				end else begin
					fw = pending_writes.pop_front();
					if (new_pixel !== fw.word) begin
						$error("new_pixel mismatch: expected %h, actual %h", fw.word, new_pixel);
						error_count <= error_count + 1;
					end
					if (write_enable !== fw.we) begin
						$error("write_enable mismatch: expected %b, actual %b", fw.we,
							write_enable);
						error_count <= error_count + 1;
					end
					if (write_x !== fw.x) begin
						$error("write_x mismatch: expected %0d, actual %0d", fw.x, write_x);
						error_count <= error_count + 1;
					end
					if (write_y !== fw.y) begin
						$error("write_y mismatch: expected %0d, actual %0d", fw.y, write_y);
						error_count <= error_count + 1;
					end
				end
			end
			if (start && !busy) begin
				pending_writes.push_back(blend_pixel(src_alpha, src_red, src_green, src_blue,
					dest_pixel, pixel_x, pixel_y));
			end
			writes_outstanding <= pending_writes.size();
		end
	end

endmodule

### bench/rgb565_alpha_blend_pixel_tb.sv
// rgb565_alpha_blend_pixel_tb: stimulus and verdict for the rgb565 alpha blender
// depends on rgb565_alpha_blend_pixel, rgb565_alpha_blend_pixel_chk and rgbab_pkg
`timescale 1ns / 1ps
module rgb565_alpha_blend_pixel_tb;

	localparam int COORD_BITS = 10;
	localparam int RANDOM_BEATS = 1250;
	// settle time after the last result
	localparam int DRAIN_CYCLES = 16;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [7:0]            src_alpha = '0;
	logic [7:0]            src_red = '0;
	logic [7:0]            src_green = '0;
	logic [7:0]            src_blue = '0;
	logic [15:0]           dest_pixel = '0;
	logic [COORD_BITS-1:0] pixel_x = '0;
	logic [COORD_BITS-1:0] pixel_y = '0;
	logic                  done;
	logic [15:0]           new_pixel;
	logic                  write_enable;
	logic [COORD_BITS-1:0] write_x;
	logic [COORD_BITS-1:0] write_y;
	int                    error_count;
	int                    writes_outstanding;

	// sender idling switch, cleared for a long back-to-back stretch
	bit                    allow_idle = 1'b1;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rgb565_alpha_blend_pixel #(
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_alpha(src_alpha),
		.src_red(src_red),
		.src_green(src_green),
		.src_blue(src_blue),
		.dest_pixel(dest_pixel),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.done(done),
		.new_pixel(new_pixel),
		.write_enable(write_enable),
		.write_x(write_x),
		.write_y(write_y)
	);

	rgb565_alpha_blend_pixel_chk #(
		.COORD_BITS(COORD_BITS)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_alpha(src_alpha),
		.src_red(src_red),
		.src_green(src_green),
		.src_blue(src_blue),
		.dest_pixel(dest_pixel),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.done(done),
		.new_pixel(new_pixel),
		.write_enable(write_enable),
		.write_x(write_x),
		.write_y(write_y),
		.error_count(error_count),
		.writes_outstanding(writes_outstanding)
	);

	// one command beat: optional idle gap with junk on the data ports, then hold start
	// until the block takes it; called right after a rising edge
	task automatic send_beat(input logic [7:0] a, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [15:0] dp, input logic [COORD_BITS-1:0] x,
		input logic [COORD_BITS-1:0] y);
		int gap;
		gap = 0;
		// each cycle idles with the same odds, so idle cycles make up about 38 in 100
		while (allow_idle && $urandom_range(0, 99) < 38)
			gap++;
		if (gap > 0) begin
			// idle cycles still carry random data so start alone has to gate it
			start      <= 1'b0;
			src_alpha  <= 8'($urandom);
			src_red    <= 8'($urandom);
			src_green  <= 8'($urandom);
			src_blue   <= 8'($urandom);
			dest_pixel <= 16'($urandom);
			pixel_x    <= COORD_BITS'($urandom);
			pixel_y    <= COORD_BITS'($urandom);
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		src_alpha  <= a;
		src_red    <= r;
		src_green  <= g;
		src_blue   <= b;
		dest_pixel <= dp;
		pixel_x    <= x;
		pixel_y    <= y;
		// busy read here is the value before the edge, which is what the block used
		do @(posedge clk); while (busy);
	endtask

	// hold off the sender until every predicted write has come back
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (writes_outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int pick;
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [15:0] dp;

		// reset held low from the start, released on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats
		// transparent source: no write, destination word handed back, coordinates still echoed
		send_beat(8'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 10'd0, 10'd0);
		send_beat(8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 10'd1023, 10'd1023);
		send_beat(8'd0, 8'h12, 8'h34, 8'h56, 16'h5555, 10'd1, 10'd512);
		// fully opaque, source extremes over opposite destinations
		send_beat(8'd255, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 10'd1023, 10'd0);
		send_beat(8'd255, 8'h00, 8'h00, 8'h00, 16'hFFFF, 10'd0, 10'd1023);
		// near-opaque range ignores the destination, low source bits dropped by the pack
		send_beat(8'd250, 8'h07, 8'h03, 8'h07, 16'hFFFF, 10'd341, 10'd682);
		send_beat(8'd254, 8'hF8, 8'hFC, 8'hF8, 16'h1234, 10'd682, 10'd341);
		send_beat(8'd251, 8'h12, 8'h34, 8'h56, 16'hABCD, 10'd512, 10'd1);
		// blend at the edges of the alpha range
		send_beat(8'd249, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 10'd5, 10'd6);
		send_beat(8'd249, 8'h00, 8'h00, 8'h00, 16'hFFFF, 10'd7, 10'd8);
		send_beat(8'd1, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 10'd9, 10'd10);
		send_beat(8'd1, 8'h00, 8'h00, 8'h00, 16'hFFFF, 10'd11, 10'd12);
		send_beat(8'd2, 8'hFE, 8'hFE, 8'hFE, 16'h0821, 10'd13, 10'd14);
		// mid-range alphas over mixed destinations
		send_beat(8'd128, 8'h80, 8'h80, 8'h80, 16'h8410, 10'd100, 10'd200);
		send_beat(8'd128, 8'hFF, 8'h00, 8'hFF, 16'h07E0, 10'd200, 10'd100);
		send_beat(8'd127, 8'h00, 8'hFF, 8'h00, 16'hF81F, 10'd300, 10'd400);
		send_beat(8'd64, 8'hAA, 8'h55, 8'hAA, 16'hA5A5, 10'd682, 10'd682);
		send_beat(8'd200, 8'h55, 8'hAA, 8'h55, 16'h5A5A, 10'd341, 10'd341);
		send_beat(8'd192, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 10'd1022, 10'd1021);
		send_beat(8'd63, 8'h00, 8'h00, 8'h00, 16'h0000, 10'd2, 10'd3);

		// empty the pipe once before the random part
		wait_for_drain();

		for (n = 0; n < RANDOM_BEATS; n++) begin
			// a long run with no idling at all
			allow_idle = !(n >= 500 && n < 750);
			// a second full drain partway through
			if (n == 900)
				wait_for_drain();

			// alpha weighted toward the transparent and opaque classes and their borders
			pick = $urandom_range(0, 99);
			if (pick < 12)
				a = 8'd0;
			else if (pick < 30)
				a = 8'($urandom_range(250, 255));
			else if (pick < 38)
				a = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd249;
			else
				a = 8'($urandom_range(1, 249));

			// channels mostly uniform, sometimes pinned to an extreme
			r = ($urandom_range(0, 9) == 0) ? {8{1'($urandom)}} : 8'($urandom);
			g = ($urandom_range(0, 9) == 0) ? {8{1'($urandom)}} : 8'($urandom);
			b = ($urandom_range(0, 9) == 0) ? {8{1'($urandom)}} : 8'($urandom);
			dp = ($urandom_range(0, 9) == 0) ? {16{1'($urandom)}} : 16'($urandom);

			send_beat(a, r, g, b, dp, COORD_BITS'($urandom), COORD_BITS'($urandom));
		end

		// wait for the last write beats, then a little longer for stray strobes
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
